FILE: sv/gif_lzw_decoder_macros.svh
// ----------------------------------------------------------------------------
// gif_lzw_decoder_macros
// Assertion macros used by the checker file of the LZW decoder.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_DECODER_MACROS_SVH
`define GIF_LZW_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Types, codes and default sizes of the GIF LZW decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

  // default sizes
  localparam int MAX_CODE_BITS   = 12;
  localparam int DICT_DEPTH      = 4096;
  localparam int PIXEL_ADDR_BITS = 24;
  localparam int CFG_W           = 24;

  // input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_NEED   = 3'd2;
  localparam logic [2:0] ST_BUSY   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_ERROR  = 3'd5;

  // error kinds
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_END_DATA = 3'd3;
  localparam logic [2:0] ERR_BAD_SIZE = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] pixel_offset;
    logic [7:0]  pixel_index;
    logic [2:0]  error_kind;
  } out_item_t;

endpackage

FILE: sv/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF image data LZW decoder with a memory-held dictionary.
// ----------------------------------------------------------------------------
// Start frame, stream byte and status answers are given in the ready state,
// as are ticks that cut a clear, end or invalid code. A tick that decodes a
// data code or emits a chained pixel first reads the dictionary memory (two
// read ports, registered data) and then forms the pixel; a data code also
// writes back the new entry. The input stalls during that later step and
// while a result waits on out_stall. Root entries are not stored but
// generated from the code, so no clearing pass runs after reset or clear
// codes. Each entry also keeps the first symbol of its string, so no prefix
// chain search is needed on insertion. cfg_ready is always high.
module gif_lzw_decoder #(
  parameter int MAX_CODE_BITS   = gld_pkg::MAX_CODE_BITS,
  parameter int DICT_DEPTH      = gld_pkg::DICT_DEPTH,
  parameter int PIXEL_ADDR_BITS = gld_pkg::PIXEL_ADDR_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  gld_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output gld_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [gld_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW    = $clog2(DICT_DEPTH);
  localparam int NFW   = AW + 1;
  localparam int BUF_W = MAX_CODE_BITS + 8;
  localparam int BCW   = $clog2(BUF_W + 1);
  localparam int PW    = PIXEL_ADDR_BITS;
  localparam int SW    = ((PW > gld_pkg::CFG_W) ? PW : gld_pkg::CFG_W) + 2;
  localparam int CMW   = ((MAX_CODE_BITS > NFW) ? MAX_CODE_BITS : NFW) + 1;

  typedef struct packed {
    logic [7:0]    sym;
    logic [AW-1:0] prefix;
    logic [11:0]   len;
    logic [7:0]    first;
  } ent_t;

  typedef enum logic [1:0] {C_READY, C_WALK, C_CODE} ctl_t;
  typedef enum logic [2:0] {PH_IDLE, PH_DECODE, PH_WALK, PH_DONE, PH_ERROR} phase_t;

  // root entries are synthesized from the code itself
  function automatic ent_t eff(input ent_t rd, input logic root, input logic [AW-1:0] a);
    ent_t e;
    e = rd;
    if (root) begin
      e.sym    = a[7:0];
      e.prefix = '0;
      e.len    = 12'd1;
      e.first  = a[7:0];
    end
    return e;
  endfunction

  // dictionary memory
  ent_t          mem [DICT_DEPTH];
  ent_t          rd_a_r, rd_b_r;
  logic          root_a_r, root_b_r;
  logic [AW-1:0] addr_a, addr_b;
  logic          we;
  logic [AW-1:0] wa;
  ent_t          wd;

  // control and decode state
  ctl_t                 ctl_r, ctl_nxt;
  phase_t               phase_r, phase_nxt;
  logic [BUF_W-1:0]     buf_r, buf_nxt;
  logic [BCW-1:0]       bcnt_r, bcnt_nxt;
  logic [7:0]           left_r, left_nxt;
  logic [3:0]           rbits_r, rbits_nxt;
  logic [3:0]           cw_r, cw_nxt;
  logic [NFW-1:0]       nf_r, nf_nxt;
  logic [AW-1:0]        prev_r, prev_nxt;
  logic                 pv_r, pv_nxt;
  logic [PW-1:0]        pw_r, pw_nxt;
  logic [PW-1:0]        mb_r, mb_nxt;
  logic [AW-1:0]        walk_r, walk_nxt;
  logic [2:0]           err_r, err_nxt;
  logic [AW-1:0]        code_r, code_nxt;
  logic [gld_pkg::CFG_W-1:0] frame_r;
  logic                 out_valid_r, out_valid_nxt;
  gld_pkg::out_item_t   out_r, out_nxt;
  logic                 out_load;

  logic                 accept;
  logic [8:0]           roots;
  logic [MAX_CODE_BITS-1:0] code_cur;
  logic [CMW-1:0]       code_x, nf_x, clr_x;
  logic [NFW-1:0]       roots_new;
  ent_t                 ea, eb, ec, ne;
  logic                 code_eq_nf, insert;
  logic [NFW-1:0]       nf_inc;
  logic [SW-1:0]        sum;
  logic [PW-1:0]        base;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (ctl_r != C_READY) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign roots    = 9'd1 << rbits_r;
  assign code_cur = MAX_CODE_BITS'(buf_r & ((BUF_W'(1) << cw_r) - BUF_W'(1)));
  assign code_x   = CMW'(code_cur);
  assign nf_x     = CMW'(nf_r);
  assign clr_x    = CMW'(roots);
  assign addr_a   = (phase_r == PH_WALK) ? walk_r : AW'(code_cur);
  assign addr_b   = prev_r;

  // next-state logic
  always_comb begin
    ctl_nxt   = ctl_r;
    phase_nxt = phase_r;
    buf_nxt   = buf_r;
    bcnt_nxt  = bcnt_r;
    left_nxt  = left_r;
    rbits_nxt = rbits_r;
    cw_nxt    = cw_r;
    nf_nxt    = nf_r;
    prev_nxt  = prev_r;
    pv_nxt    = pv_r;
    pw_nxt    = pw_r;
    mb_nxt    = mb_r;
    walk_nxt  = walk_r;
    err_nxt   = err_r;
    code_nxt  = code_r;
    out_load  = 1'b0;
    out_nxt   = '0;
    we        = 1'b0;
    wa        = nf_r[AW-1:0];
    roots_new = NFW'(1) << in_data.stream_byte[3:0];
    ea        = eff(rd_a_r, root_a_r, code_r);
    eb        = eff(rd_b_r, root_b_r, prev_r);
    code_eq_nf = (NFW'(code_r) == nf_r);
    insert    = pv_r && (nf_r < NFW'(DICT_DEPTH));
    nf_inc    = nf_r + NFW'(1);
    ne.sym    = code_eq_nf ? eb.first : ea.first;
    ne.prefix = prev_r;
    ne.len    = eb.len + 12'd1;
    ne.first  = eb.first;
    wd        = ne;
    ec        = ea;
    sum       = '0;
    base      = pw_r;

    unique case (ctl_r)
      C_READY: begin
        if (accept) begin
          out_load = 1'b1;
          out_nxt.status = gld_pkg::ST_BUSY;
          unique case (in_data.opcode)
            gld_pkg::OP_START: begin
              buf_nxt  = '0;
              bcnt_nxt = '0;
              left_nxt = '0;
              pw_nxt   = '0;
              mb_nxt   = '0;
              walk_nxt = '0;
              err_nxt  = gld_pkg::ERR_NONE;
              pv_nxt   = 1'b0;
              if (in_data.stream_byte < 8'd2 || in_data.stream_byte > 8'd8) begin
                rbits_nxt = '0;
                cw_nxt    = '0;
                nf_nxt    = '0;
                phase_nxt = PH_ERROR;
                err_nxt   = gld_pkg::ERR_BAD_SIZE;
                out_nxt.status     = gld_pkg::ST_ERROR;
                out_nxt.error_kind = gld_pkg::ERR_BAD_SIZE;
              end else begin
                rbits_nxt = in_data.stream_byte[3:0];
                cw_nxt    = in_data.stream_byte[3:0] + 4'd1;
                nf_nxt    = roots_new + NFW'(2);
                phase_nxt = PH_DECODE;
                out_nxt.status = gld_pkg::ST_ACCEPT;
              end
            end
            gld_pkg::OP_BYTE, gld_pkg::OP_TICK: begin
              if (phase_r == PH_DONE) begin
                out_nxt.status = gld_pkg::ST_DONE;
              end else if (phase_r == PH_ERROR) begin
                out_nxt.status     = gld_pkg::ST_ERROR;
                out_nxt.error_kind = err_r;
              end else if (phase_r == PH_IDLE) begin
                out_nxt.status = gld_pkg::ST_NEED;
              end else if (in_data.opcode == gld_pkg::OP_BYTE) begin
                // stream byte: length or code data
                if (phase_r != PH_DECODE || bcnt_r >= BCW'(cw_r)) begin
                  out_nxt.status = gld_pkg::ST_BUSY;
                end else if (left_r == 8'd0) begin
                  if (in_data.stream_byte == 8'd0) begin
                    phase_nxt = PH_DONE;
                    out_nxt.status = gld_pkg::ST_DONE;
                  end else begin
                    left_nxt = in_data.stream_byte;
                    out_nxt.status = gld_pkg::ST_ACCEPT;
                  end
                end else begin
                  buf_nxt  = buf_r | (BUF_W'(in_data.stream_byte) << bcnt_r);
                  bcnt_nxt = bcnt_r + BCW'(8);
                  left_nxt = left_r - 8'd1;
                  out_nxt.status = gld_pkg::ST_ACCEPT;
                end
              end else if (phase_r == PH_WALK) begin
                // pixel from the chain: wait for the memory read
                out_load = 1'b0;
                ctl_nxt  = C_WALK;
              end else if (bcnt_r < BCW'(cw_r)) begin
                out_nxt.status = gld_pkg::ST_NEED;
              end else begin
                // cut one code from the bit buffer
                buf_nxt  = buf_r >> cw_r;
                bcnt_nxt = bcnt_r - BCW'(cw_r);
                if (code_x > nf_x || (code_x == nf_x &&
                    (!pv_r || nf_r >= NFW'(DICT_DEPTH)))) begin
                  phase_nxt = PH_ERROR;
                  err_nxt   = gld_pkg::ERR_UNKNOWN;
                  out_nxt.status     = gld_pkg::ST_ERROR;
                  out_nxt.error_kind = gld_pkg::ERR_UNKNOWN;
                end else if (code_x == clr_x + CMW'(1)) begin
                  if (left_r != 8'd0) begin
                    phase_nxt = PH_ERROR;
                    err_nxt   = gld_pkg::ERR_END_DATA;
                    out_nxt.status     = gld_pkg::ST_ERROR;
                    out_nxt.error_kind = gld_pkg::ERR_END_DATA;
                  end else begin
                    phase_nxt = PH_DONE;
                    out_nxt.status = gld_pkg::ST_DONE;
                  end
                end else if (code_x == clr_x) begin
                  cw_nxt = rbits_r + 4'd1;
                  nf_nxt = NFW'(roots) + NFW'(2);
                  pv_nxt = 1'b0;
                  out_nxt.status = gld_pkg::ST_BUSY;
                end else begin
                  out_load = 1'b0;
                  code_nxt = AW'(code_cur);
                  ctl_nxt  = C_CODE;
                end
              end
            end
            default: begin
              out_nxt.status = gld_pkg::ST_BUSY;
            end
          endcase
        end
      end
      C_WALK: begin
        ec = eff(rd_a_r, root_a_r, walk_r);
        base = mb_r;
        out_load = 1'b1;
        out_nxt.status       = gld_pkg::ST_PIXEL;
        out_nxt.pixel_offset = 24'(base + PW'((ec.len == 12'd0) ? 12'd0 : ec.len - 12'd1));
        out_nxt.pixel_index  = ec.sym;
        if (ec.len <= 12'd1) phase_nxt = PH_DECODE;
        else walk_nxt = ec.prefix;
        ctl_nxt = C_READY;
      end
      C_CODE: begin
        // insert the new entry and start the string
        if (insert) begin
          we     = 1'b1;
          nf_nxt = nf_inc;
          if (16'(nf_inc) == (16'd1 << cw_r) && cw_r < 4'(MAX_CODE_BITS))
            cw_nxt = cw_r + 4'd1;
        end
        ec       = code_eq_nf ? ne : ea;
        prev_nxt = code_r;
        pv_nxt   = 1'b1;
        sum      = SW'(pw_r) + SW'(ec.len);
        out_load = 1'b1;
        ctl_nxt  = C_READY;
        if (sum > SW'(frame_r) || sum > (SW'(1) << PW)) begin
          phase_nxt = PH_ERROR;
          err_nxt   = gld_pkg::ERR_OVERFLOW;
          out_nxt.status     = gld_pkg::ST_ERROR;
          out_nxt.error_kind = gld_pkg::ERR_OVERFLOW;
        end else begin
          mb_nxt = pw_r;
          pw_nxt = PW'(sum);
          out_nxt.status       = gld_pkg::ST_PIXEL;
          out_nxt.pixel_offset = 24'(base + PW'((ec.len == 12'd0) ? 12'd0 : ec.len - 12'd1));
          out_nxt.pixel_index  = ec.sym;
          if (ec.len <= 12'd1) begin
            phase_nxt = PH_DECODE;
            walk_nxt  = code_r;
          end else begin
            phase_nxt = PH_WALK;
            walk_nxt  = ec.prefix;
          end
        end
      end
      default: ctl_nxt = C_READY;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= C_READY;
      phase_r     <= PH_IDLE;
      buf_r       <= '0;
      bcnt_r      <= '0;
      left_r      <= '0;
      rbits_r     <= '0;
      cw_r        <= '0;
      nf_r        <= '0;
      prev_r      <= '0;
      pv_r        <= 1'b0;
      pw_r        <= '0;
      mb_r        <= '0;
      walk_r      <= '0;
      err_r       <= gld_pkg::ERR_NONE;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      buf_r       <= buf_nxt;
      bcnt_r      <= bcnt_nxt;
      left_r      <= left_nxt;
      rbits_r     <= rbits_nxt;
      cw_r        <= cw_nxt;
      nf_r        <= nf_nxt;
      prev_r      <= prev_nxt;
      pv_r        <= pv_nxt;
      pw_r        <= pw_nxt;
      mb_r        <= mb_nxt;
      walk_r      <= walk_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) frame_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (out_load) out_r <= out_nxt;
  end

  // dictionary memory: two registered reads, one write
  always_ff @(posedge clk) begin
    rd_a_r   <= mem[addr_a];
    rd_b_r   <= mem[addr_b];
    root_a_r <= NFW'(addr_a) < NFW'(roots);
    root_b_r <= NFW'(addr_b) < NFW'(roots);
    if (we) mem[wa] <= wd;
  end

endmodule

FILE: sv/gif_lzw_decoder_checker.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_checker
// Port-level assertions for the LZW decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "gif_lzw_decoder_macros.svh"

module gif_lzw_decoder_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input gld_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input gld_pkg::out_item_t        out_data
);

  // a stalled result holds
  `GLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // only pixel results carry offset and index
  `GLD_ASSERT_NOW(a_pix_fields, out_valid && out_data.status != gld_pkg::ST_PIXEL, out_data.pixel_offset == 24'd0 && out_data.pixel_index == 8'd0, "pixel fields set on non-pixel result")

  // only error results carry an error kind
  `GLD_ASSERT_NOW(a_err_field, out_valid && out_data.status != gld_pkg::ST_ERROR, out_data.error_kind == gld_pkg::ERR_NONE, "error kind set on non-error result")

  // a start frame transfer answers in the next cycle
  `GLD_ASSERT_NEXT(a_start_ans, in_valid && !in_stall && in_data.opcode == gld_pkg::OP_START, out_valid && (out_data.status == gld_pkg::ST_ACCEPT || out_data.status == gld_pkg::ST_ERROR), "start frame not answered")

endmodule

bind gif_lzw_decoder gif_lzw_decoder_checker u_gld_checker (.*);
